// ----- sv/scq_pkg.sv -----
// ---------------------------------------------------------------------------
// scq_pkg: shared types, codes and keymaps for the scancode decoder queue
// Item structs, operation and status codes, set-1 scancodes and the
// unshifted/shifted keymap functions.
// ---------------------------------------------------------------------------
package scq_pkg;

    // Sizes fixed by the item format
    localparam int CHAR_W         = 8;
    localparam int LEVEL_W        = 6;
    localparam int QUEUE_DEPTH_DEF = 64;

    // Operation codes
    localparam logic [1:0] OP_KEY   = 2'd0;
    localparam logic [1:0] OP_POP   = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    // Status codes
    localparam logic [2:0] ST_NONE    = 3'd0;
    localparam logic [2:0] ST_QUEUED  = 3'd1;
    localparam logic [2:0] ST_DROPPED = 3'd2;
    localparam logic [2:0] ST_POPPED  = 3'd3;
    localparam logic [2:0] ST_EMPTY   = 3'd4;

    // Set-1 scancodes with special meaning
    localparam logic [7:0] SC_LSHIFT_MAKE  = 8'h2a;
    localparam logic [7:0] SC_RSHIFT_MAKE  = 8'h36;
    localparam logic [7:0] SC_LSHIFT_BREAK = 8'haa;
    localparam logic [7:0] SC_RSHIFT_BREAK = 8'hb6;
    localparam logic [7:0] SC_CTRL_MAKE    = 8'h1d;
    localparam logic [7:0] SC_CTRL_BREAK   = 8'h9d;
    localparam logic [7:0] SC_ENTER        = 8'h1c;
    localparam logic [7:0] SC_BACKSPACE    = 8'h0e;

    // Characters
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_CR    = 8'h0d;
    localparam logic [7:0] CH_BS    = 8'h08;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_LO_A  = 8'h61;
    localparam logic [7:0] CH_LO_Z  = 8'h7a;
    localparam logic [7:0] CH_UP_A  = 8'h41;
    localparam logic [7:0] CH_UP_Z  = 8'h5a;
    localparam logic [7:0] CTRL_LO_OFS = 8'h60;
    localparam logic [7:0] CTRL_UP_OFS = 8'h40;

    // Input and result transactions
    typedef struct packed {
        logic [1:0] operation;
        logic [7:0] scancode;
    } scq_in_t;

    typedef struct packed {
        logic [2:0]         status;
        logic [CHAR_W-1:0]  char_out;
        logic [LEVEL_W-1:0] queue_level;
    } scq_out_t;

    // Controller commands to the datapath
    typedef struct packed {
        logic accept;   // latch transaction, launch queue read
        logic commit;   // update state, load result register
    } scq_cmd_t;

    // Unshifted keymap
    function automatic logic [7:0] plain_map(input logic [6:0] k);
        logic [7:0] c;
        case (k)
            7'h02: c = 8'h31;  7'h03: c = 8'h32;  7'h04: c = 8'h33;  7'h05: c = 8'h34;
            7'h06: c = 8'h35;  7'h07: c = 8'h36;  7'h08: c = 8'h37;  7'h09: c = 8'h38;
            7'h0a: c = 8'h39;  7'h0b: c = 8'h30;  7'h0c: c = 8'h2d;  7'h0d: c = 8'h3d;
            7'h10: c = 8'h71;  7'h11: c = 8'h77;  7'h12: c = 8'h65;  7'h13: c = 8'h72;
            7'h14: c = 8'h74;  7'h15: c = 8'h79;  7'h16: c = 8'h75;  7'h17: c = 8'h69;
            7'h18: c = 8'h6f;  7'h19: c = 8'h70;  7'h1a: c = 8'h5b;  7'h1b: c = 8'h5d;
            7'h1e: c = 8'h61;  7'h1f: c = 8'h73;  7'h20: c = 8'h64;  7'h21: c = 8'h66;
            7'h22: c = 8'h67;  7'h23: c = 8'h68;  7'h24: c = 8'h6a;  7'h25: c = 8'h6b;
            7'h26: c = 8'h6c;  7'h27: c = 8'h3b;  7'h28: c = 8'h27;
            7'h2b: c = 8'h5c;  7'h2c: c = 8'h7a;  7'h2d: c = 8'h78;  7'h2e: c = 8'h63;
            7'h2f: c = 8'h76;  7'h30: c = 8'h62;  7'h31: c = 8'h6e;  7'h32: c = 8'h6d;
            7'h33: c = 8'h2c;  7'h34: c = 8'h2e;  7'h35: c = 8'h2f;  7'h39: c = 8'h20;
            default: c = CH_NUL;
        endcase
        return c;
    endfunction

    // Shifted keymap
    function automatic logic [7:0] shifted_map(input logic [6:0] k);
        logic [7:0] c;
        case (k)
            7'h02: c = 8'h21;  7'h03: c = 8'h40;  7'h04: c = 8'h23;  7'h05: c = 8'h24;
            7'h06: c = 8'h25;  7'h07: c = 8'h5e;  7'h08: c = 8'h26;  7'h09: c = 8'h2a;
            7'h0a: c = 8'h28;  7'h0b: c = 8'h29;  7'h0c: c = 8'h5f;  7'h0d: c = 8'h2b;
            7'h10: c = 8'h51;  7'h11: c = 8'h57;  7'h12: c = 8'h45;  7'h13: c = 8'h52;
            7'h14: c = 8'h54;  7'h15: c = 8'h59;  7'h16: c = 8'h55;  7'h17: c = 8'h49;
            7'h18: c = 8'h4f;  7'h19: c = 8'h50;  7'h1a: c = 8'h7b;  7'h1b: c = 8'h7d;
            7'h1e: c = 8'h41;  7'h1f: c = 8'h53;  7'h20: c = 8'h44;  7'h21: c = 8'h46;
            7'h22: c = 8'h47;  7'h23: c = 8'h48;  7'h24: c = 8'h4a;  7'h25: c = 8'h4b;
            7'h26: c = 8'h4c;  7'h27: c = 8'h3a;  7'h28: c = 8'h22;
            7'h2b: c = 8'h7c;  7'h2c: c = 8'h5a;  7'h2d: c = 8'h58;  7'h2e: c = 8'h43;
            7'h2f: c = 8'h56;  7'h30: c = 8'h42;  7'h31: c = 8'h4e;  7'h32: c = 8'h4d;
            7'h33: c = 8'h3c;  7'h34: c = 8'h3e;  7'h35: c = 8'h3f;  7'h39: c = 8'h20;
            default: c = CH_NUL;
        endcase
        return c;
    endfunction

    // Keys that still give uppercase under the Korean shifted layout (Q W E R T O P)
    function automatic logic kor_upper_key(input logic [6:0] k);
        logic r;
        case (k)
            7'h10, 7'h11, 7'h12, 7'h13, 7'h14, 7'h18, 7'h19: r = 1'b1;
            default: r = 1'b0;
        endcase
        return r;
    endfunction

endpackage

// ----- sv/scq_ram.sv -----
// ---------------------------------------------------------------------------
// scq_ram: generic single-write, single-read RAM
// One write port and one read port; read data is registered.
// ---------------------------------------------------------------------------
module scq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Storage write and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- sv/scq_ctrl.sv -----
// ---------------------------------------------------------------------------
// scq_ctrl: transaction controller
// Two-state sequencer: take a transaction, then execute it once the result
// register is free. Owns the input stall and the result valid.
// ---------------------------------------------------------------------------
module scq_ctrl
    import scq_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_stall,
    output logic     out_valid,
    input  logic     out_stall,
    output scq_cmd_t cmd
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_EXEC = 1'b1;

    logic state_reg;
    logic state_next;
    logic out_valid_reg;
    logic out_valid_next;
    logic accept;
    logic commit;

    // Handshake decode
    assign in_stall = (state_reg != S_IDLE);
    assign accept   = in_valid && !in_stall;
    // result register is free when empty or being taken this cycle
    assign commit   = (state_reg == S_EXEC) && (!out_valid_reg || !out_stall);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (commit)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Result valid
    always_comb
    begin
        if (commit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && out_stall)
        begin
            out_valid_next = 1'b1;
        end
        else
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign cmd.accept = accept;
    assign cmd.commit = commit;

    // Checks
    a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == S_EXEC))
        else $error("accepted transaction did not move to execute");

    a_commit_valid: assert property (@(posedge clk) disable iff (!rst_n)
        commit |=> out_valid_reg)
        else $error("committed result not presented");

    a_exec_hold: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_EXEC) && !commit) |=> (state_reg == S_EXEC))
        else $error("left execute without committing");

endmodule

// ----- sv/scq_datapath.sv -----
// ---------------------------------------------------------------------------
// scq_datapath: scancode decode, modifier state and character ring queue
// Latches a transaction, decodes it against the keymaps, updates the queue
// pointers and the queue RAM, and holds the result register.
// ---------------------------------------------------------------------------
module scq_datapath
    import scq_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     cfg_we,
    input  logic     cfg_wdata,
    input  scq_cmd_t cmd,
    input  scq_in_t  in_item,
    output scq_out_t out_item
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam logic [PTR_W-1:0] PTR_MAX = PTR_W'(QUEUE_DEPTH - 1);
    // wraps to zero for a power-of-two depth, where the pointer math wraps anyway
    localparam logic [PTR_W-1:0] DEPTH_P = PTR_W'(QUEUE_DEPTH);

    // Registers
    logic [1:0]         op_reg;
    logic [7:0]         sc_reg;
    logic               kor_reg;
    logic               shift_reg;
    logic               shift_next;
    logic               ctrl_reg;
    logic               ctrl_next;
    logic [PTR_W-1:0]   rp_reg;
    logic [PTR_W-1:0]   rp_next;
    logic [PTR_W-1:0]   wp_reg;
    logic [PTR_W-1:0]   wp_next;
    logic [2:0]         status_reg;
    logic [2:0]         status_next;
    logic [CHAR_W-1:0]  char_reg;
    logic [CHAR_W-1:0]  char_next;
    logic [LEVEL_W-1:0] level_reg;
    logic [LEVEL_W-1:0] level_next;

    // Decode signals
    logic [6:0]         key;
    logic [7:0]         plain_ch;
    logic [7:0]         shifted_ch;
    logic [7:0]         mapped_ch;
    logic [7:0]         key_ch;
    logic               plain_keep;
    logic               is_mod;
    logic [PTR_W-1:0]   wp_inc;
    logic [PTR_W-1:0]   rp_inc;
    logic               q_full;
    logic               q_empty;
    logic               ram_we;
    logic [CHAR_W-1:0]  ram_rdata;
    logic [PTR_W-1:0]   level_ptr;
    logic [PTR_W+LEVEL_W-1:0] level_ext;

    // Queue storage
    scq_ram #(
        .WIDTH (CHAR_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (wp_reg),
        .wdata (key_ch),
        .re    (cmd.accept),
        .raddr (rp_reg),
        .rdata (ram_rdata)
    );

    // Keymap lookup
    assign key        = sc_reg[6:0];
    assign plain_ch   = plain_map(key);
    assign shifted_ch = shifted_map(key);
    assign plain_keep = ((plain_ch >= CH_LO_A) && (plain_ch <= CH_LO_Z))
                        || (plain_ch == CH_SPACE);

    always_comb
    begin
        if (kor_reg && shift_reg)
        begin
            if (kor_upper_key(key))
            begin
                mapped_ch = shifted_ch;
            end
            else if (plain_keep)
            begin
                mapped_ch = plain_ch;
            end
            else
            begin
                mapped_ch = shifted_ch;
            end
        end
        else
        begin
            mapped_ch = shift_reg ? shifted_ch : plain_ch;
        end
    end

    // Enter/backspace and ctrl folding
    always_comb
    begin
        if (sc_reg == SC_ENTER)
        begin
            key_ch = CH_CR;
        end
        else if (sc_reg == SC_BACKSPACE)
        begin
            key_ch = CH_BS;
        end
        else if (ctrl_reg && (mapped_ch >= CH_LO_A) && (mapped_ch <= CH_LO_Z))
        begin
            key_ch = mapped_ch - CTRL_LO_OFS;
        end
        else if (ctrl_reg && (mapped_ch >= CH_UP_A) && (mapped_ch <= CH_UP_Z))
        begin
            key_ch = mapped_ch - CTRL_UP_OFS;
        end
        else
        begin
            key_ch = mapped_ch;
        end
    end

    // Queue pointer arithmetic
    assign wp_inc  = (wp_reg == PTR_MAX) ? '0 : wp_reg + 1'b1;
    assign rp_inc  = (rp_reg == PTR_MAX) ? '0 : rp_reg + 1'b1;
    assign q_full  = (wp_inc == rp_reg);
    assign q_empty = (rp_reg == wp_reg);
    assign is_mod  = (sc_reg == SC_LSHIFT_MAKE) || (sc_reg == SC_RSHIFT_MAKE)
                     || (sc_reg == SC_LSHIFT_BREAK) || (sc_reg == SC_RSHIFT_BREAK)
                     || (sc_reg == SC_CTRL_MAKE) || (sc_reg == SC_CTRL_BREAK);

    // Operation execute
    always_comb
    begin
        shift_next  = shift_reg;
        ctrl_next   = ctrl_reg;
        rp_next     = rp_reg;
        wp_next     = wp_reg;
        status_next = ST_NONE;
        char_next   = CH_NUL;
        ram_we      = 1'b0;
        case (op_reg)
            OP_KEY:
            begin
                if ((sc_reg == SC_LSHIFT_MAKE) || (sc_reg == SC_RSHIFT_MAKE))
                begin
                    shift_next = 1'b1;
                end
                else if ((sc_reg == SC_LSHIFT_BREAK) || (sc_reg == SC_RSHIFT_BREAK))
                begin
                    shift_next = 1'b0;
                end
                else if (sc_reg == SC_CTRL_MAKE)
                begin
                    ctrl_next = 1'b1;
                end
                else if (sc_reg == SC_CTRL_BREAK)
                begin
                    ctrl_next = 1'b0;
                end
                // make codes that map to a character
                if (!is_mod && !sc_reg[7] && (key_ch != CH_NUL))
                begin
                    char_next = key_ch;
                    if (q_full)
                    begin
                        status_next = ST_DROPPED;
                    end
                    else
                    begin
                        status_next = ST_QUEUED;
                        wp_next     = wp_inc;
                        ram_we      = cmd.commit;
                    end
                end
            end
            OP_POP:
            begin
                if (q_empty)
                begin
                    status_next = ST_EMPTY;
                end
                else
                begin
                    status_next = ST_POPPED;
                    char_next   = ram_rdata;
                    rp_next     = rp_inc;
                end
            end
            OP_CLEAR:
            begin
                rp_next = '0;
                wp_next = '0;
            end
            default:
            begin
                status_next = ST_NONE;
            end
        endcase
    end

    // Fill level after the step
    assign level_ptr  = wp_next - rp_next + ((wp_next < rp_next) ? DEPTH_P : '0);
    assign level_ext  = {{LEVEL_W{1'b0}}, level_ptr};
    assign level_next = level_ext[LEVEL_W-1:0];

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kor_reg   <= 1'b1;
            shift_reg <= 1'b0;
            ctrl_reg  <= 1'b0;
            rp_reg    <= '0;
            wp_reg    <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                kor_reg <= cfg_wdata;
            end
            if (cmd.commit)
            begin
                shift_reg <= shift_next;
                ctrl_reg  <= ctrl_next;
                rp_reg    <= rp_next;
                wp_reg    <= wp_next;
            end
        end
    end

    // Transaction and result payload
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            op_reg <= in_item.operation;
            sc_reg <= in_item.scancode;
        end
        if (cmd.commit)
        begin
            status_reg <= status_next;
            char_reg   <= char_next;
            level_reg  <= level_next;
        end
    end

    assign out_item.status      = status_reg;
    assign out_item.char_out    = char_reg;
    assign out_item.queue_level = level_reg;

    // Checks
    a_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
        (rp_reg <= PTR_MAX) && (wp_reg <= PTR_MAX))
        else $error("queue pointer beyond depth");

    a_push_moves_wp: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.commit && (status_next == ST_QUEUED)) |=> (wp_reg != $past(wp_reg)))
        else $error("queued character without write pointer advance");

    a_pop_moves_rp: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.commit && (status_next == ST_POPPED)) |=> (rp_reg != $past(rp_reg)))
        else $error("popped character without read pointer advance");

endmodule

// ----- sv/scancode_key_decoder_queue.sv -----
// ---------------------------------------------------------------------------
// scancode_key_decoder_queue: set-1 scancode decoder with character queue
// Flow: an accepted transaction is latched, then executed in the EXEC state;
// the result register loads when it commits, which waits while an earlier
// result is still stalled.
// Input stalls in EXEC: no new transaction is taken until the last one has
// committed; the queue RAM read is launched at accept and used in execute.
// Reset: modifiers and queue pointers clear, the Korean layout flag sets
// to 1; queue contents are undefined until written.
// ---------------------------------------------------------------------------
module scancode_key_decoder_queue
    import scq_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     cfg_we,
    input  logic     cfg_wdata,
    input  logic     in_valid,
    output logic     in_stall,
    input  scq_in_t  in_item,
    output logic     out_valid,
    input  logic     out_stall,
    output scq_out_t out_item
);

    scq_cmd_t cmd;

    // Sequencer
    scq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd)
    );

    // Decode, queue and result register
    scq_datapath #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd),
        .in_item   (in_item),
        .out_item  (out_item)
    );

endmodule
